[src/ajb_pkg.sv]
// Shared types, constants and helper functions of the audio jitter buffer.
package ajb_pkg;

    // Ring geometry
    localparam int FRAME_SAMPLES = 16;
    localparam int RING_FRAMES   = 7;
    localparam int RING_SIZE     = FRAME_SAMPLES * RING_FRAMES;

    // Widths
    localparam int DATA_W   = 16;
    localparam int PTR_W    = $clog2(RING_SIZE);
    localparam int FILL_W   = 7;
    localparam int CNT_W    = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
    localparam int PF_W     = 3;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;

    // Register reset values
    localparam logic [PF_W-1:0]   PREFETCH_RST = 3'd5;
    localparam logic [DATA_W-1:0] LIMIT_RST    = 16'd200;

    typedef enum logic [1:0] {
        KIND_ACCEPT   = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_NONE     = 2'd2,
        KIND_FRAME    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_BUFFERING = 2'd1,
        MODE_PLAYING   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ALU_INC_SAT  = 2'd0,
        ALU_ADD_WRAP = 2'd1,
        ALU_SUB_MOD  = 2'd2,
        ALU_GE       = 2'd3
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUT_NEXT,
        ST_PUT_CHK,
        ST_PUT_OVF,
        ST_GET_FILL,
        ST_GET_CMP,
        ST_GET_INC,
        ST_GET_LIM,
        ST_FRM_PTR,
        ST_FILL,
        ST_RESULT,
        ST_RD,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_alu_op           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [DATA_W-1:0] y;
        logic              flag;
    } t_alu_rsp;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } t_mem_req;

    // Fill needed to start playing; a prefetch of zero counts as one frame
    function automatic logic [DATA_W-1:0] ajb_threshold(input logic [PF_W-1:0] pf);
        logic [DATA_W-1:0] pf1;
        pf1 = (pf == '0) ? DATA_W'(1) : DATA_W'(pf);
        return DATA_W'(pf1 * DATA_W'(FRAME_SAMPLES));
    endfunction

endpackage

[src/audio_jitter_buffer_unit.sv]
// Put: pointer step, check, overflow count if full, fill, result word; ready after it is taken.
// Get, no frame: fill, compare, underflow count, limit check as needed; a single result word.
// Get with a frame: fill, compare, step, fill, then FRAME_SAMPLES words (store read, then output).
// One item at a time, all steps through one shared ALU; input is stalled until results drain.
// Synchronous active-low reset: idle mode, pointers and event counters zero, registers at defaults.
// The sample store is not cleared; only written entries are ever read.
module audio_jitter_buffer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic signed [ajb_pkg::DATA_W-1:0] i_sample_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_kind,
    output logic signed [ajb_pkg::DATA_W-1:0] o_sample_out,
    output logic                              o_last,
    output logic [ajb_pkg::FILL_W-1:0]        o_fill_level,
    output logic [1:0]                        o_mode,
    output logic [ajb_pkg::DATA_W-1:0]        o_overflow_count,
    output logic [ajb_pkg::DATA_W-1:0]        o_underflow_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ajb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ajb_pkg::DATA_W-1:0]        i_cfg_data
);

    logic [ajb_pkg::PF_W-1:0]   r_prefetch;
    logic [ajb_pkg::DATA_W-1:0] r_limit;
    ajb_pkg::t_alu_req          alu_req;
    ajb_pkg::t_alu_rsp          alu_rsp;
    ajb_pkg::t_mem_req          mem_req;
    logic [ajb_pkg::DATA_W-1:0] rdata;
    logic [ajb_pkg::DATA_W-1:0] sample_out;

    // configuration registers; writes to unused indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefetch <= ajb_pkg::PREFETCH_RST;
            r_limit    <= ajb_pkg::LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ajb_pkg::CFG_PREFETCH: r_prefetch <= i_cfg_data[ajb_pkg::PF_W-1:0];
                ajb_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ajb_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_sample_in       (i_sample_in),
        .i_prefetch        (r_prefetch),
        .i_limit           (r_limit),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_sample_out      (sample_out),
        .o_last            (o_last),
        .o_fill_level      (o_fill_level),
        .o_mode            (o_mode),
        .o_overflow_count  (o_overflow_count),
        .o_underflow_count (o_underflow_count),
        .o_alu_req         (alu_req),
        .i_alu_rsp         (alu_rsp),
        .o_mem_req         (mem_req),
        .i_rdata           (rdata)
    );

    assign o_sample_out = sample_out;

    ajb_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    ajb_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

endmodule

[src/ajb_alu.sv]
// Shared arithmetic unit: saturating increment, wrapping add, ring subtract, compare.
module ajb_alu (
    input  ajb_pkg::t_alu_req i_req,
    output ajb_pkg::t_alu_rsp o_rsp
);

    logic [ajb_pkg::DATA_W:0] sum;
    logic [ajb_pkg::DATA_W:0] diff;

    // one adder serves the wrapping add, one subtractor the ring subtract and compare
    assign sum  = {1'b0, i_req.a} + {1'b0, i_req.b};
    assign diff = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_comb begin
        o_rsp.y    = '0;
        o_rsp.flag = 1'b0;
        case (i_req.op)
            ajb_pkg::ALU_INC_SAT: begin
                o_rsp.y = (&i_req.a) ? i_req.a : i_req.a + ajb_pkg::DATA_W'(1);
            end
            ajb_pkg::ALU_ADD_WRAP: begin
                // pointer step, back to zero at the ring end
                o_rsp.y = (sum >= (ajb_pkg::DATA_W+1)'(ajb_pkg::RING_SIZE)) ?
                          '0 : sum[ajb_pkg::DATA_W-1:0];
            end
            ajb_pkg::ALU_SUB_MOD: begin
                // distance around the ring; flag marks equal operands
                o_rsp.y    = diff[ajb_pkg::DATA_W] ?
                             diff[ajb_pkg::DATA_W-1:0] + ajb_pkg::DATA_W'(ajb_pkg::RING_SIZE) :
                             diff[ajb_pkg::DATA_W-1:0];
                o_rsp.flag = (diff == '0);
            end
            ajb_pkg::ALU_GE: begin
                o_rsp.flag = ~diff[ajb_pkg::DATA_W];
            end
            default: begin
                o_rsp.y    = '0;
                o_rsp.flag = 1'b0;
            end
        endcase
    end

endmodule

[src/ajb_store.sv]
// Sample ring store: one write port, one registered read port.
module ajb_store (
    input  logic                       i_clk,
    input  ajb_pkg::t_mem_req          i_req,
    output logic [ajb_pkg::DATA_W-1:0] o_rdata
);

    logic [ajb_pkg::DATA_W-1:0] mem [ajb_pkg::RING_SIZE];
    logic [ajb_pkg::DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ajb_seq.sv]
// Sequencer: pointers, mode, counters and result words, stepping the shared ALU.
module ajb_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [ajb_pkg::DATA_W-1:0]  i_sample_in,
    input  logic [ajb_pkg::PF_W-1:0]    i_prefetch,
    input  logic [ajb_pkg::DATA_W-1:0]  i_limit,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_kind,
    output logic [ajb_pkg::DATA_W-1:0]  o_sample_out,
    output logic                        o_last,
    output logic [ajb_pkg::FILL_W-1:0]  o_fill_level,
    output logic [1:0]                  o_mode,
    output logic [ajb_pkg::DATA_W-1:0]  o_overflow_count,
    output logic [ajb_pkg::DATA_W-1:0]  o_underflow_count,
    output ajb_pkg::t_alu_req           o_alu_req,
    input  ajb_pkg::t_alu_rsp           i_alu_rsp,
    output ajb_pkg::t_mem_req           o_mem_req,
    input  logic [ajb_pkg::DATA_W-1:0]  i_rdata
);

    localparam logic [ajb_pkg::CNT_W-1:0] CNT_LAST = ajb_pkg::CNT_W'(ajb_pkg::FRAME_SAMPLES - 1);

    ajb_pkg::t_state            r_state, n_state;
    ajb_pkg::t_mode             r_mode, n_mode;
    ajb_pkg::t_kind             r_kind, n_kind;
    logic [ajb_pkg::PTR_W-1:0]  r_wp, n_wp;
    logic [ajb_pkg::PTR_W-1:0]  r_rp, n_rp;
    logic [ajb_pkg::PTR_W-1:0]  r_tmp, n_tmp;
    logic [ajb_pkg::PTR_W-1:0]  r_addr, n_addr;
    logic [ajb_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [ajb_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [ajb_pkg::DATA_W-1:0] r_ovf, n_ovf;
    logic [ajb_pkg::DATA_W-1:0] r_und, n_und;
    logic [ajb_pkg::DATA_W-1:0] r_sample, n_sample;
    logic                       r_chk_lim, n_chk_lim;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ajb_pkg::ST_IDLE;
            r_mode    <= ajb_pkg::MODE_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_ovf     <= '0;
            r_und     <= '0;
            r_fill    <= '0;
            r_chk_lim <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_ovf     <= n_ovf;
            r_und     <= n_und;
            r_fill    <= n_fill;
            r_chk_lim <= n_chk_lim;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_tmp    <= n_tmp;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_sample <= n_sample;
    end

    // next state, ALU and store requests
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_kind    = r_kind;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_tmp     = r_tmp;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_fill    = r_fill;
        n_ovf     = r_ovf;
        n_und     = r_und;
        n_sample  = r_sample;
        n_chk_lim = r_chk_lim;
        o_alu_req = '{op: ajb_pkg::ALU_SUB_MOD, a: '0, b: '0};
        o_mem_req = '{we: 1'b0, waddr: r_wp, wdata: r_sample, re: 1'b0, raddr: r_addr};

        case (r_state)
            ajb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_sample_in;
                    n_state  = i_action ? ajb_pkg::ST_GET_FILL : ajb_pkg::ST_PUT_NEXT;
                end
            end

            // put: step the write pointer, then check it against the read pointer
            ajb_pkg::ST_PUT_NEXT: begin
                o_alu_req = '{op: ajb_pkg::ALU_ADD_WRAP,
                              a: ajb_pkg::DATA_W'(r_wp), b: ajb_pkg::DATA_W'(1)};
                n_tmp   = i_alu_rsp.y[ajb_pkg::PTR_W-1:0];
                n_state = ajb_pkg::ST_PUT_CHK;
            end
            ajb_pkg::ST_PUT_CHK: begin
                o_alu_req = '{op: ajb_pkg::ALU_SUB_MOD,
                              a: ajb_pkg::DATA_W'(r_tmp), b: ajb_pkg::DATA_W'(r_rp)};
                if (i_alu_rsp.flag) begin
                    n_kind  = ajb_pkg::KIND_OVERFLOW;
                    n_state = ajb_pkg::ST_PUT_OVF;
                end else begin
                    o_mem_req.we = 1'b1;
                    n_wp   = r_tmp;
                    n_kind = ajb_pkg::KIND_ACCEPT;
                    if (r_mode == ajb_pkg::MODE_IDLE) begin
                        n_mode = ajb_pkg::MODE_BUFFERING;
                    end
                    n_state = ajb_pkg::ST_FILL;
                end
            end
            ajb_pkg::ST_PUT_OVF: begin
                o_alu_req = '{op: ajb_pkg::ALU_INC_SAT, a: r_ovf, b: '0};
                n_ovf   = i_alu_rsp.y;
                n_state = ajb_pkg::ST_FILL;
            end

            // get: fill first, then the mode decision
            ajb_pkg::ST_GET_FILL: begin
                o_alu_req = '{op: ajb_pkg::ALU_SUB_MOD,
                              a: ajb_pkg::DATA_W'(r_wp), b: ajb_pkg::DATA_W'(r_rp)};
                n_fill = i_alu_rsp.y[ajb_pkg::FILL_W-1:0];
                case (r_mode)
                    ajb_pkg::MODE_BUFFERING,
                    ajb_pkg::MODE_PLAYING: begin
                        n_state = ajb_pkg::ST_GET_CMP;
                    end
                    default: begin
                        n_kind  = ajb_pkg::KIND_NONE;
                        n_state = ajb_pkg::ST_RESULT;
                    end
                endcase
            end
            ajb_pkg::ST_GET_CMP: begin
                o_alu_req = '{op: ajb_pkg::ALU_GE, a: ajb_pkg::DATA_W'(r_fill),
                              b: (r_mode == ajb_pkg::MODE_BUFFERING) ?
                                 ajb_pkg::ajb_threshold(i_prefetch) :
                                 ajb_pkg::DATA_W'(ajb_pkg::FRAME_SAMPLES)};
                n_chk_lim = (r_mode == ajb_pkg::MODE_BUFFERING);
                if (i_alu_rsp.flag) begin
                    if (r_mode == ajb_pkg::MODE_BUFFERING) begin
                        n_mode = ajb_pkg::MODE_PLAYING;
                    end else begin
                        n_und = '0;
                    end
                    n_state = ajb_pkg::ST_FRM_PTR;
                end else begin
                    if (r_mode == ajb_pkg::MODE_PLAYING) begin
                        n_mode = ajb_pkg::MODE_BUFFERING;
                    end
                    n_state = ajb_pkg::ST_GET_INC;
                end
            end
            ajb_pkg::ST_GET_INC: begin
                o_alu_req = '{op: ajb_pkg::ALU_INC_SAT, a: r_und, b: '0};
                n_und   = i_alu_rsp.y;
                n_kind  = ajb_pkg::KIND_NONE;
                n_state = r_chk_lim ? ajb_pkg::ST_GET_LIM : ajb_pkg::ST_RESULT;
            end
            ajb_pkg::ST_GET_LIM: begin
                // give up when the count went above the limit
                o_alu_req = '{op: ajb_pkg::ALU_GE, a: i_limit, b: r_und};
                if (!i_alu_rsp.flag) begin
                    n_mode = ajb_pkg::MODE_IDLE;
                    n_und  = '0;
                end
                n_state = ajb_pkg::ST_RESULT;
            end

            // frame: advance the read pointer, keep the start address
            ajb_pkg::ST_FRM_PTR: begin
                o_alu_req = '{op: ajb_pkg::ALU_ADD_WRAP, a: ajb_pkg::DATA_W'(r_rp),
                              b: ajb_pkg::DATA_W'(ajb_pkg::FRAME_SAMPLES)};
                n_rp    = i_alu_rsp.y[ajb_pkg::PTR_W-1:0];
                n_addr  = r_rp;
                n_cnt   = '0;
                n_kind  = ajb_pkg::KIND_FRAME;
                n_state = ajb_pkg::ST_FILL;
            end

            // fill after the step, reported with every result word
            ajb_pkg::ST_FILL: begin
                o_alu_req = '{op: ajb_pkg::ALU_SUB_MOD,
                              a: ajb_pkg::DATA_W'(r_wp), b: ajb_pkg::DATA_W'(r_rp)};
                n_fill  = i_alu_rsp.y[ajb_pkg::FILL_W-1:0];
                n_state = (r_kind == ajb_pkg::KIND_FRAME) ? ajb_pkg::ST_RD : ajb_pkg::ST_RESULT;
            end

            ajb_pkg::ST_RESULT: begin
                if (!i_out_stall) begin
                    n_state = ajb_pkg::ST_IDLE;
                end
            end

            ajb_pkg::ST_RD: begin
                o_mem_req.re = 1'b1;
                n_state      = ajb_pkg::ST_OUT;
            end
            ajb_pkg::ST_OUT: begin
                o_alu_req = '{op: ajb_pkg::ALU_ADD_WRAP,
                              a: ajb_pkg::DATA_W'(r_addr), b: ajb_pkg::DATA_W'(1)};
                if (!i_out_stall) begin
                    if (r_cnt == CNT_LAST) begin
                        n_state = ajb_pkg::ST_IDLE;
                    end else begin
                        n_addr  = i_alu_rsp.y[ajb_pkg::PTR_W-1:0];
                        n_cnt   = r_cnt + ajb_pkg::CNT_W'(1);
                        n_state = ajb_pkg::ST_RD;
                    end
                end
            end

            default: begin
                n_state = ajb_pkg::ST_IDLE;
            end
        endcase
    end

    // ports
    assign o_in_stall        = (r_state != ajb_pkg::ST_IDLE);
    assign o_out_valid       = (r_state == ajb_pkg::ST_RESULT) || (r_state == ajb_pkg::ST_OUT);
    assign o_kind            = r_kind;
    assign o_sample_out      = (r_state == ajb_pkg::ST_OUT) ? i_rdata : '0;
    assign o_last            = (r_state == ajb_pkg::ST_RESULT) || (r_cnt == CNT_LAST);
    assign o_fill_level      = r_fill;
    assign o_mode            = r_mode;
    assign o_overflow_count  = r_ovf;
    assign o_underflow_count = r_und;

endmodule

[src/ajb_chk.sv]
// Port-level checks for the audio jitter buffer, bound to the top level.
module ajb_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [1:0]                        o_kind,
    input logic signed [ajb_pkg::DATA_W-1:0] o_sample_out,
    input logic                              o_last
);

    // an accepted word keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an accepted word");

    // results are only shown while the input side is held off
    a_out_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result shown while input is open");

    // put and no-frame results are single words
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != ajb_pkg::KIND_FRAME) |-> o_last)
        else $error("non-frame result without last");

    // only frame words carry a sample
    a_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != ajb_pkg::KIND_FRAME) |-> (o_sample_out == '0))
        else $error("sample on a non-frame result");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_sample_out) && $stable(o_kind) && $stable(o_last))
        else $error("stalled result word changed");

endmodule

bind audio_jitter_buffer_unit ajb_chk u_ajb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_kind       (o_kind),
    .o_sample_out (o_sample_out),
    .o_last       (o_last)
);
